/* hdl/lses_pkg.sv */
// Package: constants, types and tables shared by the LED strip effect sequencer.
`default_nettype none
package lses_pkg;

  localparam int LED_COUNT  = 8;
  localparam int LED_IDX_W  = 3;
  localparam int COLOR_W    = 8;
  localparam int NUM_CH     = 3;
  localparam int STEP_W     = 7;
  localparam int MS_W       = 8;
  localparam int MULT_W     = 17;
  localparam int PROD_W     = COLOR_W + MULT_W;
  localparam int QW_W       = 15;
  localparam int ACC_W      = COLOR_W + LED_IDX_W;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 5;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  localparam int BREATH_PERIOD     = 20;
  localparam int FLASH_PERIOD      = 250;
  localparam int FAST_FLASH_PERIOD = 100;
  localparam int FADE_PERIOD       = 20;
  localparam int CHASE_PERIOD      = 120;
  localparam int BREATH_STEPS      = 100;
  localparam int FADE_HALF         = 50;
  localparam int FADE_FULL         = 100;
  localparam int FADE_END          = 101;
  localparam int BREATH_BASE       = 36045;
  localparam int DIM_NEAR          = 35;
  localparam int DIM_FAR           = 8;
  localparam int IDLE_LEVEL        = 2;

  // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for x < 2**DIV_IN_W
  localparam int DIV_IN_W    = 15;
  localparam int RECIP_W     = 13;
  localparam int RECIP_100   = 5243;
  localparam int RECIP_SHIFT = 19;
  localparam int BREATH_SHIFT = 16;

  localparam logic [REG_IDX_W-1:0] REG_MODE  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_RED   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GREEN = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BLUE  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DONE  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_TOTAL = 3'd5;

  typedef enum logic [2:0] {
    MODE_OFF        = 3'd0,
    MODE_SOLID      = 3'd1,
    MODE_BREATH     = 3'd2,
    MODE_FLASH      = 3'd3,
    MODE_FAST_FLASH = 3'd4,
    MODE_FADE       = 3'd5,
    MODE_CHASE      = 3'd6,
    MODE_PROGRESS   = 3'd7
  } mode_e;

  typedef enum logic [2:0] {
    FRM_NONE,
    FRM_ZERO,
    FRM_COLOR,
    FRM_PROGRESS,
    FRM_SCALED,
    FRM_CHASE
  } frame_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCALE,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    SCL_MAIN,
    SCL_NEAR,
    SCL_FAR
  } scale_e;

  // channel 0 red, 1 green, 2 blue
  typedef logic [NUM_CH-1:0][COLOR_W-1:0] rgb_t;

  typedef struct packed {
    mode_e              mode;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] done;
    logic [COLOR_W-1:0] total;
  } cfg_t;

  typedef struct packed {
    logic                 accept;
    logic                 clear_acc;
    logic                 scale_issue;
    scale_e               scale_sel;
    logic                 load_led;
    logic [LED_IDX_W-1:0] led_idx;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic out_free;
  } sts_t;

  function automatic logic [QW_W-1:0] quarter_wave(input logic [4:0] k);
    logic [QW_W-1:0] v;
    case (k)
      5'd0:    v = 15'd0;
      5'd1:    v = 15'd1852;
      5'd2:    v = 15'd3696;
      5'd3:    v = 15'd5526;
      5'd4:    v = 15'd7334;
      5'd5:    v = 15'd9113;
      5'd6:    v = 15'd10856;
      5'd7:    v = 15'd12557;
      5'd8:    v = 15'd14207;
      5'd9:    v = 15'd15802;
      5'd10:   v = 15'd17334;
      5'd11:   v = 15'd18798;
      5'd12:   v = 15'd20188;
      5'd13:   v = 15'd21498;
      5'd14:   v = 15'd22723;
      5'd15:   v = 15'd23859;
      5'd16:   v = 15'd24900;
      5'd17:   v = 15'd25843;
      5'd18:   v = 15'd26684;
      5'd19:   v = 15'd27420;
      5'd20:   v = 15'd28048;
      5'd21:   v = 15'd28565;
      5'd22:   v = 15'd28969;
      5'd23:   v = 15'd29259;
      5'd24:   v = 15'd29433;
      5'd25:   v = 15'd29491;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

  // Q1.16 breathing factor for step k in 0..99
  function automatic logic [MULT_W-1:0] breath_factor(input logic [STEP_W-1:0] k);
    logic [STEP_W-1:0] idx;
    logic              neg;
    logic [QW_W-1:0]   a;
    if (k <= STEP_W'(25)) begin
      idx = k;
      neg = 1'b0;
    end else if (k <= STEP_W'(50)) begin
      idx = STEP_W'(50) - k;
      neg = 1'b0;
    end else if (k <= STEP_W'(75)) begin
      idx = k - STEP_W'(50);
      neg = 1'b1;
    end else begin
      idx = STEP_W'(100) - k;
      neg = 1'b1;
    end
    a = quarter_wave(idx[4:0]);
    if (neg) begin
      return MULT_W'(BREATH_BASE) - MULT_W'(a);
    end
    return MULT_W'(BREATH_BASE) + MULT_W'(a);
  endfunction

endpackage
`default_nettype wire

/* hdl/lses_regs.sv */
// APB configuration registers of the LED strip effect sequencer.
`default_nettype none
module lses_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [lses_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [lses_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [lses_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready,
  output lses_pkg::cfg_t                       cfg_o
);
  import lses_pkg::*;

  cfg_t                 cfg_q, cfg_d;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign idx    = paddr[APB_ADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_MODE:  cfg_d.mode  = mode_e'(pwdata[2:0]);
        REG_RED:   cfg_d.red   = pwdata[COLOR_W-1:0];
        REG_GREEN: cfg_d.green = pwdata[COLOR_W-1:0];
        REG_BLUE:  cfg_d.blue  = pwdata[COLOR_W-1:0];
        REG_DONE:  cfg_d.done  = pwdata[COLOR_W-1:0];
        REG_TOTAL: cfg_d.total = pwdata[COLOR_W-1:0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MODE:  prdata = APB_DATA_W'(cfg_q.mode);
      REG_RED:   prdata = APB_DATA_W'(cfg_q.red);
      REG_GREEN: prdata = APB_DATA_W'(cfg_q.green);
      REG_BLUE:  prdata = APB_DATA_W'(cfg_q.blue);
      REG_DONE:  prdata = APB_DATA_W'(cfg_q.done);
      REG_TOTAL: prdata = APB_DATA_W'(cfg_q.total);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

/* hdl/lses_ctrl.sv */
// Controller state machine: accept, evaluate, scale and emit sequencing.
`default_nettype none
module lses_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire lses_pkg::sts_t sts_i,
  output lses_pkg::cmd_t      cmd_o
);
  import lses_pkg::*;

  state_e               state_q, state_d;
  logic [1:0]           cnt_q, cnt_d;
  logic [LED_IDX_W-1:0] led_q, led_d;
  logic                 led_last;

  assign led_last = (led_q == LED_IDX_W'(LED_COUNT - 1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_d = sts_i.emit ? ST_SCALE : ST_IDLE;
      end
      ST_SCALE: begin
        if (cnt_q == 2'd3) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free && led_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall_o        = (state_q != ST_IDLE);
    cmd_o.accept      = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.clear_acc   = (state_q == ST_EVAL);
    cmd_o.scale_issue = (state_q == ST_SCALE) && (cnt_q != 2'd3);
    cmd_o.load_led    = (state_q == ST_EMIT) && sts_i.out_free;
    cmd_o.led_idx     = led_q;
    case (cnt_q)
      2'd0:    cmd_o.scale_sel = SCL_MAIN;
      2'd1:    cmd_o.scale_sel = SCL_NEAR;
      2'd2:    cmd_o.scale_sel = SCL_FAR;
      default: cmd_o.scale_sel = SCL_MAIN;
    endcase
  end

  // counters
  always_comb begin
    cnt_d = (state_q == ST_SCALE) ? cnt_q + 2'd1 : 2'd0;
    led_d = led_q;
    if (state_q == ST_EVAL) begin
      led_d = '0;
    end else if ((state_q == ST_EMIT) && sts_i.out_free) begin
      led_d = led_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      led_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      led_q   <= led_d;
    end
  end

endmodule
`default_nettype wire

/* hdl/lses_dp.sv */
// Datapath: effect state, color scaler pipeline, frame pixel logic and output register.
`default_nettype none
module lses_dp (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_req_i,
  input  wire lses_pkg::cfg_t                 cfg_i,
  input  wire lses_pkg::cmd_t                 cmd_i,
  output lses_pkg::sts_t                      sts_o,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [lses_pkg::LED_IDX_W-1:0]      led_index_o,
  output logic [lses_pkg::COLOR_W-1:0]        red_o,
  output logic [lses_pkg::COLOR_W-1:0]        green_o,
  output logic [lses_pkg::COLOR_W-1:0]        blue_o,
  output logic                                last_led_o
);
  import lses_pkg::*;

  localparam int Q_W = DIV_IN_W + RECIP_W;

  // effect state
  logic [STEP_W-1:0] step_q, step_d;
  logic [MS_W-1:0]   ms_q, ms_d;
  logic              fade_q, fade_d;
  frame_e            kind_q, kind_d;
  logic              breath_q, breath_d;

  logic [MS_W-1:0]   ms_inc;
  logic [STEP_W-1:0] step_mod, breath_next, fade_next, chase_next, flash_next;

  // scaler
  logic [MULT_W-1:0]                 main_mult, mult;
  logic                              div_sel;
  logic                              s1_vld_q;
  scale_e                            s1_sel_q;
  logic                              s1_div_q;
  logic [NUM_CH-1:0][PROD_W-1:0]     prod_q;
  rgb_t                              color, scaled;
  rgb_t                              lvl_main_q, lvl_near_q, lvl_far_q;
  logic [Q_W-1:0]                    quot [NUM_CH];

  // emission
  logic [ACC_W-1:0]     acc_q, acc_d;
  logic [COLOR_W-1:0]   total_eff;
  logic                 lit;
  logic [LED_IDX_W-1:0] chase_dist;
  rgb_t                 pix, pix_q;
  logic                 out_valid_q;
  logic [LED_IDX_W-1:0] idx_q;
  logic                 last_q;

  assign color = {cfg_i.blue, cfg_i.green, cfg_i.red};

  assign ms_inc      = (ms_q == '1) ? ms_q : ms_q + 1'b1;
  assign step_mod    = (step_q >= STEP_W'(BREATH_STEPS)) ? step_q - STEP_W'(BREATH_STEPS)
                                                         : step_q;
  assign breath_next = (step_mod == STEP_W'(BREATH_STEPS - 1)) ? '0 : step_mod + 1'b1;
  assign flash_next  = step_q + 1'b1;
  assign fade_next   = (step_q < STEP_W'(FADE_END)) ? step_q + 1'b1 : step_q;
  assign chase_next  = STEP_W'(LED_IDX_W'(step_q[LED_IDX_W-1:0] + 1'b1));

  always_comb begin
    step_d   = step_q;
    ms_d     = ms_q;
    fade_d   = fade_q;
    kind_d   = kind_q;
    breath_d = breath_q;
    if (cmd_i.accept) begin
      kind_d   = FRM_NONE;
      breath_d = 1'b0;
      if (start_req_i) begin
        step_d = '0;
        fade_d = 1'b0;
        case (cfg_i.mode)
          MODE_OFF:      kind_d = FRM_ZERO;
          MODE_SOLID:    kind_d = FRM_COLOR;
          MODE_PROGRESS: kind_d = FRM_PROGRESS;
          default:       kind_d = FRM_NONE;
        endcase
      end else begin
        ms_d = ms_inc;
        case (cfg_i.mode)
          MODE_BREATH: begin
            if (ms_inc >= MS_W'(BREATH_PERIOD)) begin
              ms_d     = '0;
              step_d   = breath_next;
              kind_d   = FRM_SCALED;
              breath_d = 1'b1;
            end
          end
          MODE_FLASH, MODE_FAST_FLASH: begin
            if (ms_inc >= ((cfg_i.mode == MODE_FLASH) ? MS_W'(FLASH_PERIOD)
                                                      : MS_W'(FAST_FLASH_PERIOD))) begin
              ms_d   = '0;
              step_d = flash_next;
              kind_d = flash_next[0] ? FRM_ZERO : FRM_COLOR;
            end
          end
          MODE_FADE: begin
            if (!fade_q && (ms_inc >= MS_W'(FADE_PERIOD))) begin
              ms_d   = '0;
              step_d = fade_next;
              if (fade_next <= STEP_W'(FADE_FULL)) begin
                kind_d = FRM_SCALED;
              end else begin
                kind_d = FRM_ZERO;
                fade_d = 1'b1;
              end
            end
          end
          MODE_CHASE: begin
            if (ms_inc >= MS_W'(CHASE_PERIOD)) begin
              ms_d   = '0;
              step_d = chase_next;
              kind_d = FRM_CHASE;
            end
          end
          default: kind_d = FRM_NONE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= '0;
      ms_q     <= '0;
      fade_q   <= 1'b0;
      kind_q   <= FRM_NONE;
      breath_q <= 1'b0;
    end else begin
      step_q   <= step_d;
      ms_q     <= ms_d;
      fade_q   <= fade_d;
      kind_q   <= kind_d;
      breath_q <= breath_d;
    end
  end

  assign sts_o.emit     = (kind_q != FRM_NONE);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  // main multiplier: Q1.16 breathing factor or fade numerator over 100
  always_comb begin
    if (breath_q) begin
      main_mult = breath_factor(step_q);
    end else if (step_q <= STEP_W'(FADE_HALF)) begin
      main_mult = MULT_W'({step_q, 1'b0});
    end else if (step_q <= STEP_W'(FADE_FULL)) begin
      main_mult = MULT_W'({STEP_W'(FADE_FULL) - step_q, 1'b0});
    end else begin
      main_mult = '0;
    end
  end

  always_comb begin
    case (cmd_i.scale_sel)
      SCL_MAIN: begin
        mult    = main_mult;
        div_sel = !breath_q;
      end
      SCL_NEAR: begin
        mult    = MULT_W'(DIM_NEAR);
        div_sel = 1'b1;
      end
      SCL_FAR: begin
        mult    = MULT_W'(DIM_FAR);
        div_sel = 1'b1;
      end
      default: begin
        mult    = '0;
        div_sel = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= cmd_i.scale_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_sel_q <= cmd_i.scale_sel;
    s1_div_q <= div_sel;
    for (int c = 0; c < NUM_CH; c++) begin
      prod_q[c] <= PROD_W'(color[c]) * PROD_W'(mult);
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      quot[c] = Q_W'(prod_q[c][DIV_IN_W-1:0]) * Q_W'(RECIP_100);
      if (s1_div_q) begin
        scaled[c] = quot[c][RECIP_SHIFT +: COLOR_W];
      end else begin
        scaled[c] = prod_q[c][BREATH_SHIFT +: COLOR_W];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      case (s1_sel_q)
        SCL_MAIN: lvl_main_q <= scaled;
        SCL_NEAR: lvl_near_q <= scaled;
        SCL_FAR:  lvl_far_q  <= scaled;
        default:  lvl_main_q <= scaled;
      endcase
    end
  end

  // progress: LED i lit iff i * total < done * LED_COUNT
  assign total_eff  = (cfg_i.total == '0) ? COLOR_W'(1) : cfg_i.total;
  assign lit        = acc_q < (ACC_W'(cfg_i.done) << LED_IDX_W);
  assign chase_dist = cmd_i.led_idx - step_q[LED_IDX_W-1:0];

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.clear_acc) begin
      acc_d = '0;
    end else if (cmd_i.load_led) begin
      acc_d = acc_q + ACC_W'(total_eff);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  always_comb begin
    case (kind_q)
      FRM_ZERO:     pix = '0;
      FRM_COLOR:    pix = color;
      FRM_PROGRESS: pix = lit ? color : {NUM_CH{COLOR_W'(IDLE_LEVEL)}};
      FRM_SCALED:   pix = lvl_main_q;
      FRM_CHASE: begin
        if (chase_dist == '0) begin
          pix = color;
        end else if (chase_dist == LED_IDX_W'(1)) begin
          pix = lvl_near_q;
        end else begin
          pix = lvl_far_q;
        end
      end
      default:      pix = '0;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_led) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_led) begin
      pix_q  <= pix;
      idx_q  <= cmd_i.led_idx;
      last_q <= (cmd_i.led_idx == LED_IDX_W'(LED_COUNT - 1));
    end
  end

  assign out_valid_o = out_valid_q;
  assign led_index_o = idx_q;
  assign red_o       = pix_q[0];
  assign green_o     = pix_q[1];
  assign blue_o      = pix_q[2];
  assign last_led_o  = last_q;

endmodule
`default_nettype wire

/* hdl/led_strip_effect_sequencer.sv */
// Top level of the LED strip effect sequencer: registers, controller and datapath.
// A transaction is evaluated first; a frame item then makes a scaler pass and sends its
// 8 LEDs via the output register; an item that yields no frame returns to idle after
// evaluate. Output stalls extend the LED phase, and no new item is taken meanwhile. The
// scaler is a two-stage multiply pipeline shared by the three level sets of a frame.
// Reset (rst_ni low, asynchronous) clears config, control and valid state; no clearing pass.
`default_nettype none
module led_strip_effect_sequencer (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [lses_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [lses_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [lses_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            start_req_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic      [lses_pkg::LED_IDX_W-1:0]  led_index_o,
  output logic      [lses_pkg::COLOR_W-1:0]    red_o,
  output logic      [lses_pkg::COLOR_W-1:0]    green_o,
  output logic      [lses_pkg::COLOR_W-1:0]    blue_o,
  output logic                                 last_led_o
);
  import lses_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  lses_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lses_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lses_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_req_i (start_req_i),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .led_index_o (led_index_o),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .last_led_o  (last_led_o)
  );

endmodule
`default_nettype wire

/* hdl/lses_checker.sv */
// Port-level assertions for the LED strip effect sequencer, bound to the top level.
`default_nettype none
module lses_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_stall_o,
  input wire logic                           out_valid_o,
  input wire logic                           out_stall_i,
  input wire logic [lses_pkg::LED_IDX_W-1:0] led_index_o,
  input wire logic [lses_pkg::COLOR_W-1:0]   red_o,
  input wire logic [lses_pkg::COLOR_W-1:0]   green_o,
  input wire logic [lses_pkg::COLOR_W-1:0]   blue_o,
  input wire logic                           last_led_o
);
  import lses_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(led_index_o) && $stable(red_o)
      && $stable(green_o) && $stable(blue_o) && $stable(last_led_o))
    else $error("stalled output transaction changed");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_led_o |-> led_index_o == LED_IDX_W'(LED_COUNT - 1))
    else $error("last LED flag on wrong index");

  a_busy_mid_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_led_o |-> in_stall_o)
    else $error("input taken while a frame is incomplete");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accepted transaction");

endmodule

bind led_strip_effect_sequencer lses_checker u_lses_checker (.*);
`default_nettype wire

/* test/led_strip_effect_sequencer_checker.sv */
// Checker for the LED strip effect sequencer: tracks registers, predicts frames, compares LEDs.
module led_strip_effect_sequencer_checker
  import lses_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic                  pready_i,
  input  logic [APB_ADDR_W-1:0] paddr_i,
  input  logic [APB_DATA_W-1:0] pwdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic                  start_req_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [LED_IDX_W-1:0]  led_index_i,
  input  logic [COLOR_W-1:0]    red_i,
  input  logic [COLOR_W-1:0]    green_i,
  input  logic [COLOR_W-1:0]    blue_i,
  input  logic                  last_led_i,
  output int                    mismatches_o,
  output int                    leds_pending_o,
  output int                    frames_o,
  output int                    leds_o
);

  localparam int unsigned BREATH_MS  = 20;
  localparam int unsigned FLASH_MS   = 250;
  localparam int unsigned FAST_MS    = 100;
  localparam int unsigned FADE_MS    = 20;
  localparam int unsigned CHASE_MS   = 120;
  localparam int unsigned GAIN_BASE  = 36045;
  localparam int unsigned DIM_LEVEL  = 2;

  typedef struct {
    logic [LED_IDX_W-1:0] index;
    logic [COLOR_W-1:0]   red;
    logic [COLOR_W-1:0]   green;
    logic [COLOR_W-1:0]   blue;
    logic                 last;
  } led_px_t;

  int unsigned sine_q [26] = '{
    0, 1852, 3696, 5526, 7334, 9113, 10856, 12557, 14207, 15802,
    17334, 18798, 20188, 21498, 22723, 23859, 24900, 25843, 26684, 27420,
    28048, 28565, 28969, 29259, 29433, 29491
  };

  led_px_t            frame_leds_due [$];
  cfg_t               regs;
  logic [STEP_W-1:0]  step;
  logic [MS_W-1:0]    ms_count;
  logic               fade_done;
  int                 mismatches;
  int                 frames;
  int                 leds;

  function automatic int unsigned breath_gain(input int unsigned k);
    if (k <= 25) return GAIN_BASE + sine_q[k];
    if (k <= 50) return GAIN_BASE + sine_q[50 - k];
    if (k <= 75) return GAIN_BASE - sine_q[k - 50];
    return GAIN_BASE - sine_q[100 - k];
  endfunction

  function automatic bit period_hit(input int unsigned period);
    if (ms_count < period) return 1'b0;
    ms_count = '0;
    return 1'b1;
  endfunction

  task automatic push_led(input int i, input int unsigned r, input int unsigned g,
                          input int unsigned b);
    led_px_t px;
    px.index = LED_IDX_W'(i);
    px.red   = COLOR_W'(r);
    px.green = COLOR_W'(g);
    px.blue  = COLOR_W'(b);
    px.last  = (i == LED_COUNT - 1);
    frame_leds_due.push_back(px);
  endtask

  task automatic push_frame(input int unsigned r, input int unsigned g, input int unsigned b);
    int i;
    for (i = 0; i < LED_COUNT; i++) push_led(i, r, g, b);
  endtask

  task automatic advance_strip(input logic restart);
    int unsigned r, g, b, gain, total, lit, d, num;
    int i;
    r = regs.red;
    g = regs.green;
    b = regs.blue;
    if (restart) begin
      step = '0;
      fade_done = 1'b0;
      case (regs.mode)
        MODE_OFF: push_frame(0, 0, 0);
        MODE_SOLID: push_frame(r, g, b);
        MODE_PROGRESS: begin
          total = (regs.total == 0) ? 1 : regs.total;
          lit = (regs.done * LED_COUNT + total - 1) / total;
          if (regs.done > 0 && lit == 0) lit = 1;
          if (lit > LED_COUNT) lit = LED_COUNT;
          for (i = 0; i < LED_COUNT; i++) begin
            if (i < lit) push_led(i, r, g, b);
            else push_led(i, DIM_LEVEL, DIM_LEVEL, DIM_LEVEL);
          end
        end
        default: ;
      endcase
    end else begin
      if (ms_count != '1) ms_count = ms_count + 1'b1;
      case (regs.mode)
        MODE_BREATH: begin
          if (period_hit(BREATH_MS)) begin
            step = STEP_W'((step % 100 + 1) % 100);
            gain = breath_gain(step);
            push_frame((r * gain) >> 16, (g * gain) >> 16, (b * gain) >> 16);
          end
        end
        MODE_FLASH, MODE_FAST_FLASH: begin
          if (period_hit(regs.mode == MODE_FLASH ? FLASH_MS : FAST_MS)) begin
            step = step + 1'b1;
            if (!step[0]) push_frame(r, g, b);
            else push_frame(0, 0, 0);
          end
        end
        MODE_FADE: begin
          if (!fade_done) begin
            if (period_hit(FADE_MS)) begin
              if (step < 101) step = step + 1'b1;
              if (step <= 50) begin
                push_frame(r * step / 50, g * step / 50, b * step / 50);
              end else if (step <= 100) begin
                push_frame(r * (100 - step) / 50, g * (100 - step) / 50, b * (100 - step) / 50);
              end else begin
                fade_done = 1'b1;
                push_frame(0, 0, 0);
              end
            end
          end
        end
        MODE_CHASE: begin
          if (period_hit(CHASE_MS)) begin
            step = STEP_W'((step % LED_COUNT + 1) % LED_COUNT);
            for (i = 0; i < LED_COUNT; i++) begin
              d = (i + LED_COUNT - step) % LED_COUNT;
              num = (d == 0) ? 100 : ((d == 1) ? 35 : 8);
              push_led(i, r * num / 100, g * num / 100, b * num / 100);
            end
          end
        end
        default: ;
      endcase
    end
  endtask

  task automatic check_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    led_px_t want;
    if (!rst_ni) begin
      regs = '0;
      step = '0;
      ms_count = '0;
      fade_done = 1'b0;
      frame_leds_due.delete();
      mismatches = 0;
      frames = 0;
      leds = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[APB_ADDR_W-1:2])
          REG_MODE:  regs.mode  = mode_e'(pwdata_i[2:0]);
          REG_RED:   regs.red   = pwdata_i[COLOR_W-1:0];
          REG_GREEN: regs.green = pwdata_i[COLOR_W-1:0];
          REG_BLUE:  regs.blue  = pwdata_i[COLOR_W-1:0];
          REG_DONE:  regs.done  = pwdata_i[COLOR_W-1:0];
          REG_TOTAL: regs.total = pwdata_i[COLOR_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        leds++;
        if (last_led_i) frames++;
        if (frame_leds_due.size() == 0) begin
          $display("%0t: unexpected LED transaction: expected none, got led %0d rgb %0d/%0d/%0d last %0b",
                   $time, led_index_i, red_i, green_i, blue_i, last_led_i);
          mismatches++;
        end else begin
          want = frame_leds_due.pop_front();
          check_field("led_index", want.index, led_index_i);
          check_field("red", want.red, red_i);
          check_field("green", want.green, green_i);
          check_field("blue", want.blue, blue_i);
          check_field("last_led", want.last, last_led_i);
        end
      end
      if (in_valid_i && !in_stall_i) advance_strip(start_req_i);
    end
    mismatches_o   <= mismatches;
    leds_pending_o <= frame_leds_due.size();
    frames_o       <= frames;
    leds_o         <= leds;
  end

endmodule

/* test/led_strip_effect_sequencer_tb.sv */
// Testbench top for the LED strip effect sequencer: clock, reset, stimulus, pacing and verdict.
module led_strip_effect_sequencer_tb;
  import lses_pkg::*;

  localparam int CYCLE_LIMIT   = 200_000;
  localparam int SETTLE_CYCLES = 24;
  localparam int LONG_HOLD     = 400;
  localparam int ITEM_TARGET   = 130;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  start_req = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [LED_IDX_W-1:0]  led_index;
  logic [COLOR_W-1:0]    red;
  logic [COLOR_W-1:0]    green;
  logic [COLOR_W-1:0]    blue;
  logic                  last_led;

  int mismatch_count;
  int leds_pending;
  int frames_checked;
  int leds_checked;
  int items_sent = 0;
  int starts_sent = 0;
  int ticks_sent = 0;
  int cycle_count = 0;
  bit burst = 1'b0;
  bit hold_req = 1'b0;

  always #10 clk_i = ~clk_i;

  led_strip_effect_sequencer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .start_req_i (start_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .led_index_o (led_index),
    .red_o       (red),
    .green_o     (green),
    .blue_o      (blue),
    .last_led_o  (last_led)
  );

  led_strip_effect_sequencer_checker frame_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .pready_i       (pready),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .start_req_i    (start_req),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .led_index_i    (led_index),
    .red_i          (red),
    .green_i        (green),
    .blue_i         (blue),
    .last_led_i     (last_led),
    .mismatches_o   (mismatch_count),
    .leds_pending_o (leds_pending),
    .frames_o       (frames_checked),
    .leds_o         (leds_checked)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d LEDs still due", $time, cycle_count,
               leds_pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int sender_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (burst || roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [COLOR_W-1:0] pick_level();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return COLOR_W'($urandom_range(1, 10));
      default: return COLOR_W'($urandom());
    endcase
  endfunction

  task automatic send_item(input logic restart);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    start_req <= restart;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    items_sent++;
    if (restart) starts_sent++;
    else ticks_sent++;
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'($urandom()), value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // drain all due LEDs, then give a tick still in flight time to finish
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (leds_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_effect(input mode_e mode, input int r, input int g, input int b,
                            input int done, input int total);
    settle();
    write_reg(REG_MODE, {5'($urandom()), mode});
    write_reg(REG_RED, COLOR_W'(r));
    write_reg(REG_GREEN, COLOR_W'(g));
    write_reg(REG_BLUE, COLOR_W'(b));
    write_reg(REG_DONE, COLOR_W'(done));
    write_reg(REG_TOTAL, COLOR_W'(total));
  endtask

  task automatic run_phase(input mode_e mode, input bit restart, input int tick_count,
                           input bit stray, input bit squeeze);
    settle();
    write_reg(REG_MODE, {5'($urandom()), mode});
    if ($urandom_range(0, 1)) write_reg(REG_RED, pick_level());
    if ($urandom_range(0, 1)) write_reg(REG_GREEN, pick_level());
    if ($urandom_range(0, 1)) write_reg(REG_BLUE, pick_level());
    if ($urandom_range(0, 1)) write_reg(REG_DONE, pick_level());
    if ($urandom_range(0, 1)) write_reg(REG_TOTAL, pick_level());
    burst = ($urandom_range(0, 3) == 0);
    if (squeeze) hold_req = 1'b1;
    if (restart) send_item(1'b1);
    repeat (tick_count) send_item(stray && $urandom_range(0, 39) == 0);
    burst = 1'b0;
  endtask

  initial begin : out_pacing
    int calm_left;
    int roll;
    bit hold_done;
    calm_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      roll = $urandom_range(0, 99);
      if (hold_req && !hold_done) begin
        // long hold while ticks keep coming, so the block backs up into its input
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_stall <= 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        out_stall <= 1'b0;
      end else if (roll < 4) begin
        calm_left = $urandom_range(50, 300);
        out_stall <= 1'b0;
      end else if (roll < 7) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(8, 30)) @(posedge clk_i);
      end else begin
        out_stall <= (roll < 30);
      end
    end
  end

  initial begin : stimulus
    int phase;
    int n;
    mode_e mode;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset config: mode off
    send_item(1'b1);
    set_effect(MODE_SOLID, 255, 255, 255, 0, 0);
    send_item(1'b1);
    set_effect(MODE_SOLID, 255, 0, 170, 0, 0);
    send_item(1'b1);
    send_item(1'b1);
    set_effect(MODE_OFF, 255, 255, 255, 255, 255);
    send_item(1'b1);
    // progress: zero total, overflow, ceiling, minimum of one lit
    set_effect(MODE_PROGRESS, 10, 20, 30, 0, 0);
    send_item(1'b1);
    set_effect(MODE_PROGRESS, 255, 128, 1, 255, 0);
    send_item(1'b1);
    set_effect(MODE_PROGRESS, 0, 255, 0, 1, 255);
    send_item(1'b1);
    set_effect(MODE_PROGRESS, 1, 2, 3, 3, 8);
    send_item(1'b1);
    set_effect(MODE_PROGRESS, 200, 100, 50, 7, 3);
    send_item(1'b1);
    set_effect(MODE_PROGRESS, 255, 255, 255, 255, 255);
    send_item(1'b1);
    set_effect(MODE_PROGRESS, 77, 0, 255, 1, 9);
    send_item(1'b1);
    set_effect(MODE_PROGRESS, 9, 99, 199, 200, 201);
    send_item(1'b1);
    set_effect(MODE_BREATH, 255, 255, 255, 0, 0);
    send_item(1'b1);
    set_effect(MODE_FLASH, 255, 0, 0, 0, 0);
    send_item(1'b1);
    set_effect(MODE_FAST_FLASH, 0, 255, 0, 0, 0);
    send_item(1'b1);
    set_effect(MODE_FADE, 0, 0, 255, 0, 0);
    send_item(1'b1);
    set_effect(MODE_CHASE, 255, 255, 255, 0, 0);
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b0);
    send_item(1'b0);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase)
        0: run_phase(MODE_BREATH, 1'b1, 45, 1'b0, 1'b1);
        1: run_phase(MODE_FADE, 1'b0, 22, 1'b0, 1'b0);
        default: begin
          mode = mode_e'($urandom_range(0, 7));
          case (mode)
            MODE_BREATH, MODE_FADE: n = $urandom_range(0, 25);
            default: n = $urandom_range(0, 8);
          endcase
          run_phase(mode, $urandom_range(0, 3) != 0, n, 1'b1, 1'b0);
        end
      endcase
      phase++;
    end
    settle();

    $display("Sent %0d transactions (%0d starts, %0d ticks) over %0d phases;",
             items_sent, starts_sent, ticks_sent, phase);
    $display("checked %0d LEDs in %0d frames over the effect modes, stale steps and a long hold.",
             leds_checked, frames_checked);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/lses_pkg.sv
hdl/lses_regs.sv
hdl/lses_ctrl.sv
hdl/lses_dp.sv
hdl/led_strip_effect_sequencer.sv
hdl/lses_checker.sv
test/led_strip_effect_sequencer_checker.sv
test/led_strip_effect_sequencer_tb.sv
